// File: rtl/tz_offset_transition_search_unit_defines.svh
// Assertion macros for the checker file of the offset search unit.
// Self-contained; included by the checker module.
`ifndef TZ_OFFSET_TRANSITION_SEARCH_UNIT_DEFINES_SVH
`define TZ_OFFSET_TRANSITION_SEARCH_UNIT_DEFINES_SVH

// Property checked on every rising edge outside of reset.
`define TZO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define TZO_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/tzo_pkg.sv
// Package for the time-zone offset search unit: sizes, request and register
// codes, controller states and the controller/datapath command and status structs.
package tzo_pkg;

    localparam int TRANS_DEPTH = 1024;
    localparam int TYPE_DEPTH  = 256;

    localparam int TRANS_AW = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
    localparam int TYPE_AW  = (TYPE_DEPTH > 1) ? $clog2(TYPE_DEPTH) : 1;
    localparam int LOHI_W   = TRANS_AW + 1;
    localparam int SCAN_W   = TYPE_AW + 1;

    localparam int TRANS_CNT_W = 11;
    localparam int TYPE_CNT_W  = 9;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int REQ_W       = 2;
    localparam int IDX_W       = 10;
    localparam int TIME_W      = 64;
    localparam int TTYPE_W     = 8;
    localparam int OFF_W       = 32;

    localparam logic [REQ_W-1:0] REQ_LOAD_TRANS = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_TYPE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT  = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_LAST_WAIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_TYPE_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_trans;
        logic wr_type;
        logic start;
        logic rd_mid;
        logic step;
        logic rd_last;
        logic tidx_last;
        logic rd_scan;
        logic scan_next;
        logic tidx_scan;
        logic tidx_zero;
        logic rd_type;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic srch_go;
        logic lo_zero;
        logic scan_go;
        logic scan_hit;
        logic out_busy;
    } t_stat;

endpackage

// File: rtl/tzo_req_if.sv
// Request channel: valid/ready handshake with load and query payload.
// Depends on tzo_pkg for field widths.
interface tzo_req_if import tzo_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [IDX_W-1:0]     entry_index;
    logic signed [TIME_W-1:0] trans_time;
    logic [TTYPE_W-1:0]   trans_type;
    logic signed [OFF_W-1:0]  type_offset;
    logic                 type_is_dst;
    logic signed [TIME_W-1:0] query_secs;

    modport source (
        output valid, req_type, entry_index, trans_time, trans_type,
               type_offset, type_is_dst, query_secs,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, trans_time, trans_type,
               type_offset, type_is_dst, query_secs,
        output ready
    );
endinterface

// File: rtl/tzo_rsp_if.sv
// Response channel: valid/ready handshake carrying found and the UTC offset.
// Depends on tzo_pkg for field widths.
interface tzo_rsp_if import tzo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [OFF_W-1:0] utc_offset;

    modport source (output valid, found, utc_offset, input ready);
    modport sink   (input valid, found, utc_offset, output ready);
endinterface

// File: rtl/tz_offset_transition_search_unit.sv
// A load beat writes its entry as it is taken. A query runs one binary-search step
// per read and compare (ceil(log2(n+1)) steps, at most 11 for 1024 transitions), then
// fetches the type and registers the result. A query before all transitions swaps the
// last-entry read for a read and compare per type entry scanned. One item is in flight
// at a time; the single read port of each table sets the pace. Synchronous active-low
// reset clears the controller state, the count registers and the response valid flag.
//
// Top level: ties the controller, the datapath and the two channels.
// Depends on tzo_pkg, tzo_req_if, tzo_rsp_if, tzo_ctrl and tzo_dp.
module tz_offset_transition_search_unit import tzo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tzo_req_if.sink               i_req,
    tzo_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // The controller walks one query through the search, the optional scan
    // for the first standard time type, and the final type lookup. The
    // datapath owns both tables, each with one write and one registered read
    // port, so every search step is a read cycle followed by a compare cycle.
    t_cmd  cmd;
    t_stat stat;

    tzo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    // The result register parts the channels: the next beat is taken while a
    // finished result still waits, and a query only stalls at its very end.
    tzo_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_entry_index    (i_req.entry_index),
        .i_trans_time     (i_req.trans_time),
        .i_trans_type     (i_req.trans_type),
        .i_type_offset    (i_req.type_offset),
        .i_type_is_dst    (i_req.type_is_dst),
        .i_query_secs     (i_req.query_secs),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_valid      (o_rsp.valid),
        .o_rsp_found      (o_rsp.found),
        .o_rsp_utc_offset (o_rsp.utc_offset)
    );

endmodule

// File: rtl/tzo_ctrl.sv
// Controller state machine of the offset search unit.
// Depends on tzo_pkg; drives the datapath through t_cmd, reads t_stat.
module tzo_ctrl import tzo_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [REQ_W-1:0] i_req_type,
    input  t_stat            i_stat,
    output logic             o_req_ready,
    output t_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req_type == REQ_QUERY) begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_stat.srch_go) begin
                    n_state = S_SRCH_CMP;
                end else if (i_stat.lo_zero) begin
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_LAST_WAIT;
                end
            end
            S_SRCH_CMP:  n_state = S_SRCH_RD;
            S_LAST_WAIT: n_state = S_TYPE_RD;
            S_SCAN_RD: begin
                n_state = i_stat.scan_go ? S_SCAN_CMP : S_TYPE_RD;
            end
            S_SCAN_CMP: begin
                n_state = i_stat.scan_hit ? S_TYPE_RD : S_SCAN_RD;
            end
            S_TYPE_RD: n_state = S_DONE;
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.wr_trans = (i_req_type == REQ_LOAD_TRANS);
                    o_cmd.wr_type  = (i_req_type == REQ_LOAD_TYPE);
                    o_cmd.start    = (i_req_type == REQ_QUERY);
                end
            end
            S_SRCH_RD: begin
                o_cmd.rd_mid  = i_stat.srch_go;
                o_cmd.rd_last = !i_stat.srch_go && !i_stat.lo_zero;
            end
            S_SRCH_CMP:  o_cmd.step      = 1'b1;
            S_LAST_WAIT: o_cmd.tidx_last = 1'b1;
            S_SCAN_RD: begin
                o_cmd.rd_scan   = i_stat.scan_go;
                o_cmd.tidx_zero = !i_stat.scan_go;
            end
            S_SCAN_CMP: begin
                o_cmd.tidx_scan = i_stat.scan_hit;
                o_cmd.scan_next = !i_stat.scan_hit;
            end
            S_TYPE_RD: o_cmd.rd_type = 1'b1;
            S_DONE:    o_cmd.emit    = !i_stat.out_busy;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/tzo_dp.sv
// Datapath of the offset search unit: count registers, transition and type
// memories, search bounds, fallback scan counter and the result register.
// Depends on tzo_pkg; controlled by tzo_ctrl through t_cmd and t_stat.
module tzo_dp import tzo_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [TIME_W-1:0] i_trans_time,
    input  logic [TTYPE_W-1:0]       i_trans_type,
    input  logic signed [OFF_W-1:0]  i_type_offset,
    input  logic                     i_type_is_dst,
    input  logic signed [TIME_W-1:0] i_query_secs,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_rsp_ready,
    output logic                     o_rsp_valid,
    output logic                     o_rsp_found,
    output logic signed [OFF_W-1:0]  o_rsp_utc_offset
);

    // Transition entry is {time, type}; type entry is {offset, dst}.
    logic [TIME_W+TTYPE_W-1:0] r_trans_mem [TRANS_DEPTH];
    logic [OFF_W:0]            r_type_mem  [TYPE_DEPTH];

    logic [TRANS_CNT_W-1:0]    r_trans_count;
    logic [TYPE_CNT_W-1:0]     r_type_count;
    logic signed [TIME_W-1:0]  r_query;
    logic [LOHI_W-1:0]         r_lo;
    logic [LOHI_W-1:0]         r_hi;
    logic [SCAN_W-1:0]         r_scan;
    logic [TTYPE_W-1:0]        r_tidx;
    logic [TIME_W+TTYPE_W-1:0] r_trans_rd;
    logic [OFF_W:0]            r_type_rd;
    logic                      r_out_valid;
    logic                      r_found;
    logic signed [OFF_W-1:0]   r_offset;

    logic [LOHI_W-1:0]         n_trans_lim;
    logic [SCAN_W-1:0]         n_type_lim;
    logic [LOHI_W:0]           mid_sum;
    logic [LOHI_W-1:0]         mid;
    logic [LOHI_W-1:0]         last;
    logic                      time_le;
    logic                      tidx_ok;
    logic                      trans_wr_ok;
    logic                      type_wr_ok;
    logic [TRANS_AW-1:0]       trans_rd_addr;
    logic [TYPE_AW-1:0]        type_rd_addr;

    // Counts above the table depth saturate to the depth.
    assign n_trans_lim = LOHI_W'((32'(r_trans_count) > 32'(TRANS_DEPTH)) ?
                                 32'(TRANS_DEPTH) : 32'(r_trans_count));
    assign n_type_lim  = SCAN_W'((32'(r_type_count) > 32'(TYPE_DEPTH)) ?
                                 32'(TYPE_DEPTH) : 32'(r_type_count));

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[LOHI_W:1];
    assign last    = r_lo - LOHI_W'(1);
    assign time_le = $signed(r_trans_rd[TIME_W+TTYPE_W-1:TTYPE_W]) <= r_query;
    assign tidx_ok = 32'(r_tidx) < 32'(n_type_lim);

    assign trans_wr_ok = 32'(i_entry_index) < 32'(TRANS_DEPTH);
    assign type_wr_ok  = 32'(i_entry_index) < 32'(TYPE_DEPTH);

    assign trans_rd_addr = i_cmd.rd_last ? TRANS_AW'(last) : TRANS_AW'(mid);
    assign type_rd_addr  = i_cmd.rd_scan ? TYPE_AW'(r_scan) : TYPE_AW'(r_tidx);

    assign o_stat.srch_go  = r_lo < r_hi;
    assign o_stat.lo_zero  = (r_lo == '0);
    assign o_stat.scan_go  = r_scan < n_type_lim;
    assign o_stat.scan_hit = !r_type_rd[0];
    assign o_stat.out_busy = r_out_valid && !i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_count <= '0;
            r_type_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRANS_COUNT: r_trans_count <= TRANS_CNT_W'(i_cfg_data);
                CFG_TYPE_COUNT:  r_type_count  <= TYPE_CNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_trans && trans_wr_ok) begin
            r_trans_mem[TRANS_AW'(i_entry_index)] <= {i_trans_time, i_trans_type};
        end
        if (i_cmd.rd_mid || i_cmd.rd_last) begin
            r_trans_rd <= r_trans_mem[trans_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_type && type_wr_ok) begin
            r_type_mem[TYPE_AW'(i_entry_index)] <= {i_type_offset, i_type_is_dst};
        end
        if (i_cmd.rd_scan || i_cmd.rd_type) begin
            r_type_rd <= r_type_mem[type_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_query <= i_query_secs;
            r_lo    <= '0;
            r_hi    <= n_trans_lim;
            r_scan  <= '0;
        end
        if (i_cmd.step) begin
            if (time_le) begin
                r_lo <= mid + LOHI_W'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.scan_next) begin
            r_scan <= r_scan + SCAN_W'(1);
        end
        if (i_cmd.tidx_last) begin
            r_tidx <= r_trans_rd[TTYPE_W-1:0];
        end else if (i_cmd.tidx_scan) begin
            r_tidx <= TTYPE_W'(r_scan);
        end else if (i_cmd.tidx_zero) begin
            r_tidx <= '0;
        end
        if (i_cmd.emit) begin
            r_found  <= tidx_ok;
            r_offset <= tidx_ok ? $signed(r_type_rd[OFF_W:1]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp_valid      = r_out_valid;
    assign o_rsp_found      = r_found;
    assign o_rsp_utc_offset = r_offset;

endmodule

// File: rtl/tzo_check.sv
// Port-level checker for the offset search unit, bound to the top level.
// Depends on tzo_pkg and the assertion macros header.
`include "tz_offset_transition_search_unit_defines.svh"

module tzo_check import tzo_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_req_valid,
    input logic                    i_req_ready,
    input logic [REQ_W-1:0]        i_req_type,
    input logic                    i_rsp_valid,
    input logic                    i_rsp_ready,
    input logic                    i_rsp_found,
    input logic signed [OFF_W-1:0] i_rsp_utc_offset
);

    `TZO_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid, "response beat dropped before it was taken")
    `TZO_ASSERT(a_not_found_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp_found |-> i_rsp_utc_offset == '0, "offset not zero on a failed lookup")
    `TZO_ASSERT(a_load_silent, i_clk, i_rst_n, i_req_valid && i_req_ready && i_req_type != REQ_QUERY && !i_rsp_valid |=> !i_rsp_valid, "result appeared after a load beat")
    `TZO_ASSERT(a_query_latency, i_clk, i_rst_n, i_req_valid && i_req_ready && i_req_type == REQ_QUERY && !i_rsp_valid |=> !i_rsp_valid, "query answered in one cycle")
    `TZO_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_rsp_valid, "response valid right after reset")

endmodule

bind tz_offset_transition_search_unit tzo_check u_tzo_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_req_type       (i_req.req_type),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_found      (o_rsp.found),
    .i_rsp_utc_offset (o_rsp.utc_offset)
);
